[src/mmsvl_pkg.sv]
// shared constants and codes for the multimap sorted value lookup block
// no dependencies

package mmsvl_pkg;

   localparam int ENTRIES_DEFAULT     = 1024;
   localparam int VALUE_BITS_DEFAULT  = 12;
   localparam int MAX_RESULTS_DEFAULT = 64;

   localparam int KEY_BITS   = 64;
   localparam int COUNT_BITS = 11;
   localparam int KIND_BITS  = 2;
   localparam int COUNT_SAT  = 2047;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_QUERY  = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_ACK   = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_MATCH = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_NONE  = 2'd2;

endpackage

[src/multimap_sorted_value_lookup_top.sv]
// multimap of 64-bit keys to values with sorted lookup of all values under a key
// depends on mmsvl_pkg
// insert: acknowledge appears in the output register in the cycle after the request is taken
// query: one scan of the pair memory per distinct matching value emitted, and one scan
//   when nothing matches; results then leave one by one through the output register,
//   the cost set by the single read port of the pair memory
// reset: synchronous, clears fill count, state and output valid; memory keeps contents

module multimap_sorted_value_lookup_top #(
   parameter int ENTRIES     = mmsvl_pkg::ENTRIES_DEFAULT,
   parameter int VALUE_BITS  = mmsvl_pkg::VALUE_BITS_DEFAULT,
   parameter int MAX_RESULTS = mmsvl_pkg::MAX_RESULTS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_action,
   input  logic [mmsvl_pkg::KEY_BITS-1:0]     req_key,
   input  logic [VALUE_BITS-1:0]              req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mmsvl_pkg::KIND_BITS-1:0]    rsp_kind,
   output logic                               rsp_refused,
   output logic [mmsvl_pkg::COUNT_BITS-1:0]   rsp_match_count,
   output logic [VALUE_BITS-1:0]              rsp_found_value,
   output logic                               rsp_last,
   output logic                               rsp_truncated
);
   import mmsvl_pkg::*;

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int EW = $clog2(MAX_RESULTS + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_type;

   logic [KEY_BITS-1:0]   key_mem [ENTRIES];
   logic [VALUE_BITS-1:0] val_mem [ENTRIES];

   state_type             state_ff, state_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [KEY_BITS-1:0]   rd_key_ff;
   logic [VALUE_BITS-1:0] rd_val_ff;
   logic [KEY_BITS-1:0]   qkey_ff, qkey_in;
   logic                  have_prev_ff, have_prev_in;
   logic [VALUE_BITS-1:0] prev_ff, prev_in;
   logic [CW-1:0]         total_ff, total_in;
   logic                  cand_ok_ff, cand_ok_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [CW-1:0]         cand_cnt_ff, cand_cnt_in;
   logic [EW-1:0]         emitted_ff, emitted_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]  rsp_kind_ff, rsp_kind_in;
   logic                  rsp_refused_ff, rsp_refused_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_trunc_ff, rsp_trunc_in;

   logic                  rsp_free;
   logic                  req_take;
   logic                  wr_en;
   logic                  match;
   logic                  eligible;
   logic [31:0]           limit;
   logic                  is_last;
   logic                  full;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == ST_IDLE && rsp_free);
   assign req_take  = req_valid && !req_stall;
   assign full      = 32'(fill_ff) >= 32'(ENTRIES);
   assign wr_en     = req_take && req_action == ACT_INSERT && !full;

   assign match    = rd_valid_ff && rd_key_ff == qkey_ff;
   assign eligible = match && (!have_prev_ff || rd_val_ff > prev_ff);
   assign limit    = (32'(total_ff) > 32'(MAX_RESULTS)) ? 32'(MAX_RESULTS) : 32'(total_ff);
   assign is_last  = 32'(emitted_ff) + 32'd1 == limit;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[fill_ff[AW-1:0]] <= req_key;
         val_mem[fill_ff[AW-1:0]] <= req_value;
      end
      rd_key_ff <= key_mem[addr_ff[AW-1:0]];
      rd_val_ff <= val_mem[addr_ff[AW-1:0]];
   end

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      addr_in        = addr_ff;
      rd_valid_in    = 1'b0;
      qkey_in        = qkey_ff;
      have_prev_in   = have_prev_ff;
      prev_in        = prev_ff;
      total_in       = total_ff;
      cand_ok_in     = cand_ok_ff;
      cand_in        = cand_ff;
      cand_cnt_in    = cand_cnt_ff;
      emitted_in     = emitted_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_refused_in = rsp_refused_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_trunc_in   = rsp_trunc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_action == ACT_INSERT) begin
                  if (!full) begin
                     fill_in = fill_ff + CW'(1);
                  end
                  rsp_valid_in   = 1'b1;
                  rsp_kind_in    = KIND_ACK;
                  rsp_refused_in = full;
                  rsp_count_in   = '0;
                  rsp_value_in   = '0;
                  rsp_last_in    = 1'b1;
                  rsp_trunc_in   = 1'b0;
               end else begin
                  qkey_in      = req_key;
                  have_prev_in = 1'b0;
                  total_in     = '0;
                  cand_ok_in   = 1'b0;
                  cand_cnt_in  = '0;
                  emitted_in   = '0;
                  addr_in      = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (addr_ff < fill_ff) begin
               rd_valid_in = 1'b1;
               addr_in     = addr_ff + CW'(1);
            end else if (!rd_valid_ff) begin
               state_in = ST_EMIT;
            end
            if (match && !have_prev_ff) begin
               total_in = total_ff + CW'(1);
            end
            if (eligible) begin
               if (!cand_ok_ff || rd_val_ff < cand_ff) begin
                  cand_ok_in  = 1'b1;
                  cand_in     = rd_val_ff;
                  cand_cnt_in = CW'(1);
               end else if (rd_val_ff == cand_ff) begin
                  cand_cnt_in = cand_cnt_ff + CW'(1);
               end
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_refused_in = 1'b0;
               if (total_ff == '0) begin
                  rsp_kind_in  = KIND_NONE;
                  rsp_count_in = '0;
                  rsp_value_in = '0;
                  rsp_last_in  = 1'b1;
                  rsp_trunc_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_kind_in  = KIND_MATCH;
                  rsp_count_in = (32'(total_ff) > 32'(COUNT_SAT)) ?
                                 COUNT_BITS'(COUNT_SAT) : COUNT_BITS'(total_ff);
                  rsp_value_in = cand_ff;
                  rsp_last_in  = is_last;
                  rsp_trunc_in = 32'(total_ff) > 32'(MAX_RESULTS);
                  emitted_in   = emitted_ff + EW'(1);
                  cand_cnt_in  = cand_cnt_ff - CW'(1);
                  if (is_last) begin
                     state_in = ST_IDLE;
                  end else if (cand_cnt_ff == CW'(1)) begin
                     have_prev_in = 1'b1;
                     prev_in      = cand_ff;
                     cand_ok_in   = 1'b0;
                     cand_cnt_in  = '0;
                     addr_in      = '0;
                     state_in     = ST_SCAN;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         have_prev_ff <= 1'b0;
         total_ff     <= '0;
         cand_ok_ff   <= 1'b0;
         cand_cnt_ff  <= '0;
         emitted_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         addr_ff      <= addr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         have_prev_ff <= have_prev_in;
         total_ff     <= total_in;
         cand_ok_ff   <= cand_ok_in;
         cand_cnt_ff  <= cand_cnt_in;
         emitted_ff   <= emitted_in;
      end
      qkey_ff        <= qkey_in;
      prev_ff        <= prev_in;
      cand_ff        <= cand_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_refused_ff <= rsp_refused_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_trunc_ff   <= rsp_trunc_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_refused     = rsp_refused_ff;
   assign rsp_match_count = rsp_count_ff;
   assign rsp_found_value = rsp_value_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_truncated   = rsp_trunc_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= 32'(ENTRIES))
      else $error("fill count beyond capacity");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_NONE |-> rsp_last_ff && !rsp_trunc_ff)
      else $error("empty query result not final");

   a_insert_ack: assert property (@(posedge clock) disable iff (reset)
      req_take && req_action == ACT_INSERT |=> rsp_valid_ff && rsp_kind_ff == KIND_ACK)
      else $error("insert not acknowledged");

   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      32'(emitted_ff) <= 32'(MAX_RESULTS))
      else $error("too many results emitted");

endmodule

[dv/mmsvl_checker.sv]
// checker for the multimap sorted value lookup block: watches both channels, predicts
// the responses of every accepted request and compares them field by field
// depends on mmsvl_pkg

module mmsvl_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_action,
   input  logic [mmsvl_pkg::KEY_BITS-1:0]    req_key,
   input  logic [11:0]                       req_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [mmsvl_pkg::KIND_BITS-1:0]   rsp_kind,
   input  logic                              rsp_refused,
   input  logic [mmsvl_pkg::COUNT_BITS-1:0]  rsp_match_count,
   input  logic [11:0]                       rsp_found_value,
   input  logic                              rsp_last,
   input  logic                              rsp_truncated,
   output int                                fails,
   output int                                pending,
   output int                                stored
);
   import mmsvl_pkg::*;

   localparam int ENTRIES     = ENTRIES_DEFAULT;
   localparam int MAX_RESULTS = MAX_RESULTS_DEFAULT;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic                  refused;
      logic [COUNT_BITS-1:0] match_count;
      logic [11:0]           found_value;
      logic                  last;
      logic                  truncated;
   } lookup_rsp_type;

   logic [KEY_BITS-1:0] pair_key [ENTRIES];
   logic [11:0]         pair_val [ENTRIES];
   int                  fill;
   lookup_rsp_type      expected_q[$];

   task automatic report(input string field, input int got, input int want);
      $display("mismatch on %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      fails++;
   endtask

   task automatic predict_request(input logic act, input logic [KEY_BITS-1:0] k,
                                  input logic [11:0] v);
      logic [11:0] hits[$];
      lookup_rsp_type r;
      int total;
      int n;
      r = '0;
      if (act == ACT_INSERT) begin
         r.kind = KIND_ACK;
         r.last = 1'b1;
         if (fill >= ENTRIES) begin
            r.refused = 1'b1;
         end else begin
            pair_key[fill] = k;
            pair_val[fill] = v;
            fill++;
         end
         expected_q.insert(expected_q.size(), r);
      end else begin
         for (int i = 0; i < fill; i++)
            if (pair_key[i] == k) hits.insert(hits.size(), pair_val[i]);
         total = hits.size();
         if (total == 0) begin
            r.kind = KIND_NONE;
            r.last = 1'b1;
            expected_q.insert(expected_q.size(), r);
         end else begin
            hits.sort();
            n = (total > MAX_RESULTS) ? MAX_RESULTS : total;
            for (int j = 0; j < n; j++) begin
               r.kind        = KIND_MATCH;
               r.match_count = (total > COUNT_SAT) ? COUNT_BITS'(COUNT_SAT)
                                                   : COUNT_BITS'(total);
               r.found_value = hits[j];
               r.last        = (j == n - 1);
               r.truncated   = (total > MAX_RESULTS);
               expected_q.insert(expected_q.size(), r);
            end
         end
      end
   endtask

   task automatic check_response();
      lookup_rsp_type e;
      if (expected_q.size() == 0) begin
         report("unexpected response", 1, 0);
      end else begin
         e = expected_q.pop_front();
         if (rsp_kind !== e.kind) report("kind", int'(rsp_kind), int'(e.kind));
         if (rsp_refused !== e.refused)
            report("refused", int'(rsp_refused), int'(e.refused));
         if (rsp_match_count !== e.match_count)
            report("match_count", int'(rsp_match_count), int'(e.match_count));
         if (rsp_found_value !== e.found_value)
            report("found_value", int'(rsp_found_value), int'(e.found_value));
         if (rsp_last !== e.last) report("last", int'(rsp_last), int'(e.last));
         if (rsp_truncated !== e.truncated)
            report("truncated", int'(rsp_truncated), int'(e.truncated));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill  = 0;
         fails = 0;
         expected_q.delete();
      end else begin
         if (req_valid && !req_stall) predict_request(req_action, req_key, req_value);
         if (rsp_valid && !rsp_stall) check_response();
      end
      pending <= expected_q.size();
      stored  <= fill;
   end

endmodule

[dv/tb.sv]
// testbench top for the multimap sorted value lookup block: directed and random
// requests under several idle and stall mixes, verdict from mmsvl_checker
// depends on mmsvl_pkg, multimap_sorted_value_lookup_top and mmsvl_checker

module tb;
   import mmsvl_pkg::*;

   localparam int LIMIT = 30000000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_action;
   logic [KEY_BITS-1:0]   req_key;
   logic [11:0]           req_value;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_BITS-1:0]  rsp_kind;
   logic                  rsp_refused;
   logic [COUNT_BITS-1:0] rsp_match_count;
   logic [11:0]           rsp_found_value;
   logic                  rsp_last;
   logic                  rsp_truncated;

   int fails, pending, stored;
   int idle_pct, stall_pct;
   int hold_left = 0;
   int cycles = 0;
   logic hold_start;
   logic [KEY_BITS-1:0] key_pool[8];
   logic [KEY_BITS-1:0] crowd_key;

   multimap_sorted_value_lookup_top u_top (.*);

   mmsvl_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_start) hold_left <= 2000;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      rsp_stall <= (hold_left > 1) || ($urandom_range(99) < stall_pct);
   end

   function automatic logic [KEY_BITS-1:0] rand_key();
      return {$urandom, $urandom};
   endfunction

   task automatic send(input logic act, input logic [KEY_BITS-1:0] k, input logic [11:0] v);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_key   <= rand_key();
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_action <= act;
      req_key    <= k;
      req_value  <= v;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_mix(input int phase);
      case (phase % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 82; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 82; end
         default: begin idle_pct = 14; stall_pct = 14; end
      endcase
   endtask

   initial begin
      logic [KEY_BITS-1:0] k;
      int n;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_action = ACT_INSERT;
      req_key    = '0;
      req_value  = '0;
      hold_start = 1'b0;
      idle_pct   = 0;
      stall_pct  = 0;
      foreach (key_pool[i]) key_pool[i] = rand_key();
      crowd_key = rand_key();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, empty query, duplicates and ordering
      send(ACT_QUERY, '0, 12'hfff);
      send(ACT_INSERT, '0, 12'd0);
      send(ACT_INSERT, '1, 12'hfff);
      send(ACT_INSERT, '1, 12'd0);
      send(ACT_INSERT, '1, 12'hfff);
      send(ACT_QUERY, '0, 12'd0);
      send(ACT_QUERY, '1, 12'd0);
      send(ACT_QUERY, 64'h0000_0000_0000_0001, 12'd0);
      send(ACT_INSERT, key_pool[0], 12'd5);
      send(ACT_INSERT, key_pool[0], 12'd3);
      send(ACT_INSERT, key_pool[0], 12'd3);
      send(ACT_INSERT, key_pool[0], 12'haaa);
      send(ACT_INSERT, key_pool[0], 12'h555);
      send(ACT_QUERY, key_pool[0], 12'd0);
      send(ACT_QUERY, ~key_pool[0], 12'd0);

      // more matches than the response limit
      for (int i = 0; i < 70; i++) send(ACT_INSERT, crowd_key, 12'($urandom_range(4095)));
      send(ACT_QUERY, crowd_key, 12'd0);
      drain();

      // long receiver hold-off while requests keep coming
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      for (int i = 0; i < 20; i++)
         send(ACT_INSERT, key_pool[3'(i % 8)], 12'($urandom_range(4095)));
      send(ACT_QUERY, key_pool[1], 12'd0);
      drain();

      for (int i = 0; i < 180; i++) begin
         if (i % 45 == 0) set_mix(i / 45);
         n = $urandom_range(99);
         k = (n < 10) ? rand_key() : key_pool[3'($urandom_range(7))];
         if ($urandom_range(99) < 45) send(ACT_QUERY, k, 12'($urandom_range(4095)));
         else send(ACT_INSERT, k, 12'($urandom_range(4095)));
      end
      set_mix(0);
      drain();

      // fill the store, then refused inserts and queries on a full store
      n = ENTRIES_DEFAULT - stored;
      for (int i = 0; i < n; i++) send(ACT_INSERT, rand_key(), 12'($urandom_range(4095)));
      drain();
      set_mix(3);
      send(ACT_INSERT, key_pool[2], 12'hfff);
      send(ACT_INSERT, '1, 12'd0);
      send(ACT_QUERY, key_pool[2], 12'd0);
      send(ACT_QUERY, crowd_key, 12'd0);
      drain();
      repeat (30) @(posedge clock);

      if (fails == 0 && pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
